@@ rtl/core/bfer_pkg.sv @@
package bfer_pkg;

  localparam int NODE_COUNT_DEF = 1024;
  localparam int DIST_WIDTH_DEF = 32;

  localparam int NODE_IN_W   = 10;
  localparam int WEIGHT_W    = 16;
  localparam int OUT_DIST_W  = 32;
  localparam int SUM_W       = 64;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 96;

  localparam int FUNC_RELAX   = 0;
  localparam int FUNC_RESTART = 1;

  // reciprocal scaling for the node index reduction
  localparam int RECIP_SH  = 20;
  localparam int QPROD_W   = NODE_IN_W + RECIP_SH;
  localparam int REM_W     = 27;

endpackage

@@ rtl/core/bellman_ford_edge_relaxer_top.sv @@
// Shortest-path edge relaxation engine over an on-chip distance table.
// Input channel s_axis: one item is either an edge to relax (tuser = 0) or a
// restart (tuser = 1). tdata carries source node, destination node and edge
// weight; tlast marks the last edge of a pass and is echoed on the output.
// Output channel m_axis: exactly one item per input item, in order. tdata
// carries the destination distance after the step and the running weight
// sum; tuser is set when the edge lowered the destination distance.
// Node indices are reduced modulo NODE_COUNT.
// A relax item goes through index reduction (quotient, then remainder);
// then the single-ported distance memory is read for the source, read for
// the destination and, if the edge lowers it, written back, in turn.
// A restart runs the clearing sweep, which writes every table entry once
// (infinity, entry zero set to zero).
// After reset the same sweep runs before the first item is accepted.
// The result sits in an output register; the next item is accepted and
// processed while it waits, and only the hand-over of a new result stalls
// until the receiver takes the old one.
module bellman_ford_edge_relaxer_top
  import bfer_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF,
  parameter int DIST_WIDTH = DIST_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // src_node, dst_node, edge_weight, zero pad
  input  logic                   s_axis_tuser,  // func
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // dst_distance, weight_sum
  output logic                   m_axis_tuser,  // relaxed
  output logic                   m_axis_tlast
);

  localparam int IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int RECIP = (1 << RECIP_SH) / NODE_COUNT;
  localparam int EXT_W = ((DIST_WIDTH > WEIGHT_W) ? DIST_WIDTH : WEIGHT_W) + 1;

  localparam logic [DIST_WIDTH-1:0] DIST_INF = {DIST_WIDTH{1'b1}};
  localparam logic [DIST_WIDTH-1:0] DIST_CAP = DIST_INF - DIST_WIDTH'(1);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_QUO  = 3'd2;
  localparam logic [2:0] S_REM  = 3'd3;
  localparam logic [2:0] S_RDS  = 3'd4;
  localparam logic [2:0] S_RDD  = 3'd5;
  localparam logic [2:0] S_UPD  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [DIST_WIDTH-1:0] dist_mem [NODE_COUNT];
  logic [DIST_WIDTH-1:0] rd_data;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [DIST_WIDTH-1:0] wr_data;

  logic [2:0]            state;
  logic [IDX_W-1:0]      clr_addr;
  logic                  pend_out;
  logic                  out_load;

  logic                  func;
  logic [NODE_IN_W-1:0]  src_raw;
  logic [NODE_IN_W-1:0]  dst_raw;
  logic [WEIGHT_W-1:0]   weight;
  logic                  last;
  logic [NODE_IN_W-1:0]  src_quo;
  logic [NODE_IN_W-1:0]  dst_quo;
  logic [IDX_W-1:0]      src_idx;
  logic [IDX_W-1:0]      dst_idx;
  logic [DIST_WIDTH-1:0] src_dist;
  logic [SUM_W-1:0]      sum_acc;

  logic                  res_relaxed;
  logic [OUT_DIST_W-1:0] res_dist;

  logic [QPROD_W-1:0]    src_qprod;
  logic [QPROD_W-1:0]    dst_qprod;
  logic [REM_W-1:0]      src_rem;
  logic [REM_W-1:0]      dst_rem;
  logic [REM_W-1:0]      src_red;
  logic [REM_W-1:0]      dst_red;

  logic [EXT_W-1:0]      path_full;
  logic [DIST_WIDTH-1:0] path_sum;
  logic                  do_relax;
  logic [SUM_W-1:0]      new_dist_wide;
  logic [SUM_W-1:0]      init_dist_wide;

  assign s_axis_tready = (state == S_IDLE);
  assign out_load      = (state == S_OUT) && (!m_axis_tvalid || m_axis_tready);

  // index reduction: quotient estimate by reciprocal, then one correction
  assign src_qprod = QPROD_W'(src_raw) * QPROD_W'(RECIP);
  assign dst_qprod = QPROD_W'(dst_raw) * QPROD_W'(RECIP);
  assign src_rem   = REM_W'(src_raw) - REM_W'(src_quo) * REM_W'(NODE_COUNT);
  assign dst_rem   = REM_W'(dst_raw) - REM_W'(dst_quo) * REM_W'(NODE_COUNT);
  assign src_red   = (src_rem >= REM_W'(NODE_COUNT)) ? src_rem - REM_W'(NODE_COUNT) : src_rem;
  assign dst_red   = (dst_rem >= REM_W'(NODE_COUNT)) ? dst_rem - REM_W'(NODE_COUNT) : dst_rem;

  // saturating path length
  assign path_full = EXT_W'(src_dist) + EXT_W'(weight);
  assign path_sum  = (path_full >= EXT_W'(DIST_CAP)) ? DIST_CAP : path_full[DIST_WIDTH-1:0];
  assign do_relax  = (src_dist != DIST_INF) && (rd_data > path_sum);

  assign new_dist_wide  = do_relax ? SUM_W'(path_sum) : SUM_W'(rd_data);
  assign init_dist_wide = (dst_red == REM_W'(0)) ? SUM_W'(0) : SUM_W'(DIST_INF);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = src_idx;
    wr_en   = 1'b0;
    wr_addr = dst_idx;
    wr_data = path_sum;
    case (state)
      S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = (clr_addr == IDX_W'(0)) ? DIST_WIDTH'(0) : DIST_INF;
      end
      S_RDS: begin
        rd_en = 1'b1;
      end
      S_RDD: begin
        rd_en   = 1'b1;
        rd_addr = dst_idx;
      end
      S_UPD: begin
        wr_en = do_relax;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      dist_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= dist_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      clr_addr      <= '0;
      pend_out      <= 1'b0;
      sum_acc       <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          if (clr_addr == IDX_W'(NODE_COUNT - 1)) begin
            clr_addr <= '0;
            state    <= pend_out ? S_OUT : S_IDLE;
          end else begin
            clr_addr <= clr_addr + IDX_W'(1);
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            func    <= s_axis_tuser;
            src_raw <= s_axis_tdata[NODE_IN_W-1:0];
            dst_raw <= s_axis_tdata[2*NODE_IN_W-1:NODE_IN_W];
            weight  <= s_axis_tdata[2*NODE_IN_W+WEIGHT_W-1:2*NODE_IN_W];
            last    <= s_axis_tlast;
            state   <= S_QUO;
          end
        end
        S_QUO: begin
          src_quo <= src_qprod[QPROD_W-1:RECIP_SH];
          dst_quo <= dst_qprod[QPROD_W-1:RECIP_SH];
          state   <= S_REM;
        end
        S_REM: begin
          src_idx <= src_red[IDX_W-1:0];
          dst_idx <= dst_red[IDX_W-1:0];
          if (func == 1'(FUNC_RESTART)) begin
            sum_acc     <= '0;
            res_relaxed <= 1'b0;
            res_dist    <= init_dist_wide[OUT_DIST_W-1:0];
            pend_out    <= 1'b1;
            clr_addr    <= '0;
            state       <= S_CLR;
          end else begin
            state <= S_RDS;
          end
        end
        S_RDS: begin
          state <= S_RDD;
        end
        S_RDD: begin
          src_dist <= rd_data;
          state    <= S_UPD;
        end
        S_UPD: begin
          sum_acc     <= sum_acc + SUM_W'(weight);
          res_relaxed <= do_relax;
          res_dist    <= new_dist_wide[OUT_DIST_W-1:0];
          state       <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            m_axis_tdata  <= {sum_acc, res_dist};
            m_axis_tuser  <= res_relaxed;
            m_axis_tlast  <= last;
            pend_out      <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
